/* hw/rtl/pid_controller_integral_bleed_top_assert.svh */
// assertion macros for the pid controller checker
`ifndef PID_CONTROLLER_INTEGRAL_BLEED_TOP_ASSERT_SVH
`define PID_CONTROLLER_INTEGRAL_BLEED_TOP_ASSERT_SVH

// clocked assertion, switched off while reset is high
`define PIDIB_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pidib assertion failed");

// clocked assertion that also holds through reset
`define PIDIB_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("pidib assertion failed");

`endif

/* hw/rtl/pidib_pkg.sv */
// shared types and constants of the pid controller with integral bleed
package pidib_pkg;

   localparam int DATA_WIDTH      = 32;
   localparam int THRESH_WIDTH    = DATA_WIDTH - 1;
   localparam int CSR_INDEX_WIDTH = 3;

   typedef logic signed [DATA_WIDTH-1:0]   data_type;
   typedef logic        [THRESH_WIDTH-1:0] thresh_type;
   typedef logic        [CSR_INDEX_WIDTH-1:0] csr_index_type;

   // register indexes
   localparam csr_index_type CSR_KP_GAIN   = 3'd0;
   localparam csr_index_type CSR_KI_GAIN   = 3'd1;
   localparam csr_index_type CSR_KD_GAIN   = 3'd2;
   localparam csr_index_type CSR_OUT_MIN   = 3'd3;
   localparam csr_index_type CSR_OUT_MAX   = 3'd4;
   localparam csr_index_type CSR_THRESHOLD = 3'd5;
   localparam csr_index_type CSR_AUTO_MODE = 3'd6;

   // reset limits: -256.0 and +256.0 in q16.16
   localparam data_type OUT_MIN_RESET = -32'sd16777216;
   localparam data_type OUT_MAX_RESET = 32'sd16777216;

   typedef struct packed {
      data_type setpoint;
      data_type measurement;
      data_type external_rate;
      logic     use_external_rate;
      logic     clear_memory;
   } req_payload_type;

   typedef struct packed {
      data_type drive;
      logic     updated;
   } rsp_payload_type;

endpackage

/* hw/rtl/pidib_term.sv */
// gain times operand, floored after dropping the fraction bits
module pidib_term
   import pidib_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  data_type                                      gain,
   input  data_type                                      operand,
   output logic signed [2*DATA_WIDTH-FRAC_BITS-1:0]      term
);

   localparam int PROD_WIDTH = 2 * DATA_WIDTH;

   logic signed [PROD_WIDTH-1:0] product;

   assign product = PROD_WIDTH'(gain) * PROD_WIDTH'(operand);
   // dropping low bits of a two's complement value floors it
   assign term    = product[PROD_WIDTH-1:FRAC_BITS];

endmodule

/* hw/rtl/pidib_clamp.sv */
// clamp a wide signed value to the lower then the upper limit
module pidib_clamp
   import pidib_pkg::*;
#(
   parameter int IN_WIDTH = 48
) (
   input  logic signed [IN_WIDTH-1:0] value,
   input  data_type                   lower,
   input  data_type                   upper,
   output data_type                   result
);

   logic signed [IN_WIDTH-1:0] lower_ext;
   logic signed [IN_WIDTH-1:0] upper_ext;
   logic signed [IN_WIDTH-1:0] low_done;
   logic signed [IN_WIDTH-1:0] high_done;

   assign lower_ext = IN_WIDTH'(lower);
   assign upper_ext = IN_WIDTH'(upper);

   // lower first, so inverted limits end at the upper one
   assign low_done  = (value < lower_ext) ? lower_ext : value;
   assign high_done = (low_done > upper_ext) ? upper_ext : low_done;
   assign result    = high_done[DATA_WIDTH-1:0];

endmodule

/* hw/rtl/pid_controller_integral_bleed_top.sv */
// pid controller with integral bleed and derivative on measurement
//
// usage
// - req channel: one beat per sample (setpoint, measurement, external rate,
//   rate select, clear); rsp channel: one beat per sample (drive, updated)
// - csr port: write enable, register index, data; write only while idle
// - path: a beat taken is held in the input register, computed from there and
//   written into the result register, which drives rsp
// - throughput: one sample per cycle while rsp is not stalled; integral and
//   previous measurement are updated in the same single pass that uses them,
//   so samples never wait on each other
// - rsp stall: the result register holds; one more sample can still be
//   taken into the input register, after that req_stall rises
// - reset: clears both stages, integral, previous measurement and held
//   drive, and loads the register defaults (gains 0, limits -256 / +256,
//   threshold 0, automatic mode)
// - manual mode or clear: drive repeats the held value with updated low
module pid_controller_integral_bleed_top
   import pidib_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic            clock,
   input  logic            reset,
   // sample input
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   // result output
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   // register writes
   input  logic            csr_write_en,
   input  csr_index_type   csr_index,
   input  data_type        csr_write_data
);

   // product width after dropping fraction bits, and the sum widths
   localparam int TERM_WIDTH  = 2 * DATA_WIDTH - FRAC_BITS;
   localparam int INTEG_WIDTH = TERM_WIDTH + 1;
   localparam int DRIVE_WIDTH = TERM_WIDTH + 2;

   // saturate a one bit wider difference to the data range
   function automatic data_type sat_diff(input logic signed [DATA_WIDTH:0] diff);
      data_type res;
      if (diff[DATA_WIDTH] != diff[DATA_WIDTH-1]) begin
         res = diff[DATA_WIDTH] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                                : {1'b0, {(DATA_WIDTH-1){1'b1}}};
      end else begin
         res = diff[DATA_WIDTH-1:0];
      end
      return res;
   endfunction

   // configuration registers
   data_type   kp_gain_ff;
   data_type   ki_gain_ff;
   data_type   kd_gain_ff;
   data_type   out_min_ff;
   data_type   out_max_ff;
   thresh_type threshold_ff;
   logic       auto_mode_ff;

   // controller state
   data_type integral_ff;
   data_type prev_meas_ff;
   data_type held_drive_ff;

   // input stage and result stage
   req_payload_type in_ff;
   logic            in_valid_ff;
   logic            in_valid_in;
   rsp_payload_type rsp_ff;
   rsp_payload_type rsp_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;

   logic req_accept;
   logic advance;
   logic fire;
   logic do_update;

   // datapath
   data_type                      err;
   data_type                      err_mag;
   data_type                      rate;
   logic                          accumulate;
   logic signed [TERM_WIDTH-1:0]  kp_term;
   logic signed [TERM_WIDTH-1:0]  ki_term;
   logic signed [TERM_WIDTH-1:0]  kd_term;
   logic signed [INTEG_WIDTH-1:0] integ_sum;
   data_type                      integral_in;
   logic signed [DRIVE_WIDTH-1:0] drive_sum;
   data_type                      drive_in;

   // ---------------------------------------------------------------------
   // handshake: the result register frees when it is empty or being taken
   // ---------------------------------------------------------------------
   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign fire       = in_valid_ff && advance;
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign do_update  = fire && !in_ff.clear_memory && auto_mode_ff;

   always_comb begin
      priority if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      priority if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (advance) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // ---------------------------------------------------------------------
   // error, rate and the accumulate or bleed choice
   // ---------------------------------------------------------------------
   assign err = sat_diff((DATA_WIDTH+1)'(in_ff.setpoint) -
                         (DATA_WIDTH+1)'(in_ff.measurement));
   // magnitude read as unsigned, so the most negative error still fits
   assign err_mag    = err[DATA_WIDTH-1] ? -err : err;
   assign accumulate = unsigned'(err_mag) >= {1'b0, threshold_ff};

   assign rate = in_ff.use_external_rate ? in_ff.external_rate
               : sat_diff((DATA_WIDTH+1)'(in_ff.measurement) -
                          (DATA_WIDTH+1)'(prev_meas_ff));

   pidib_term #(.FRAC_BITS(FRAC_BITS)) u_kp_term (
      .gain    (kp_gain_ff),
      .operand (err),
      .term    (kp_term)
   );

   pidib_term #(.FRAC_BITS(FRAC_BITS)) u_ki_term (
      .gain    (ki_gain_ff),
      .operand (err),
      .term    (ki_term)
   );

   pidib_term #(.FRAC_BITS(FRAC_BITS)) u_kd_term (
      .gain    (kd_gain_ff),
      .operand (rate),
      .term    (kd_term)
   );

   // integral: add ki term, or bleed to three quarters with a floor shift
   always_comb begin
      if (accumulate) begin
         integ_sum = INTEG_WIDTH'(integral_ff) + INTEG_WIDTH'(ki_term);
      end else begin
         integ_sum = INTEG_WIDTH'(data_type'(integral_ff - (integral_ff >>> 2)));
      end
   end

   pidib_clamp #(.IN_WIDTH(INTEG_WIDTH)) u_integ_clamp (
      .value  (integ_sum),
      .lower  (out_min_ff),
      .upper  (out_max_ff),
      .result (integral_in)
   );

   // exact sum of the three terms before the output clamp
   assign drive_sum = DRIVE_WIDTH'(kp_term) + DRIVE_WIDTH'(integral_in) -
                      DRIVE_WIDTH'(kd_term);

   pidib_clamp #(.IN_WIDTH(DRIVE_WIDTH)) u_drive_clamp (
      .value  (drive_sum),
      .lower  (out_min_ff),
      .upper  (out_max_ff),
      .result (drive_in)
   );

   // result beat: new drive when updated, else the held one
   always_comb begin
      rsp_in         = rsp_ff;
      if (fire) begin
         rsp_in.drive   = do_update ? drive_in : held_drive_ff;
         rsp_in.updated = do_update;
      end
   end

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload stages need no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_ff <= req_payload;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff   <= '0;
         prev_meas_ff  <= '0;
         held_drive_ff <= '0;
      end else if (fire) begin
         if (in_ff.clear_memory) begin
            integral_ff  <= '0;
            prev_meas_ff <= '0;
         end else if (auto_mode_ff) begin
            integral_ff   <= integral_in;
            prev_meas_ff  <= in_ff.measurement;
            held_drive_ff <= drive_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_gain_ff   <= '0;
         ki_gain_ff   <= '0;
         kd_gain_ff   <= '0;
         out_min_ff   <= OUT_MIN_RESET;
         out_max_ff   <= OUT_MAX_RESET;
         threshold_ff <= '0;
         auto_mode_ff <= 1'b1;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_KP_GAIN:   kp_gain_ff   <= csr_write_data;
            CSR_KI_GAIN:   ki_gain_ff   <= csr_write_data;
            CSR_KD_GAIN:   kd_gain_ff   <= csr_write_data;
            CSR_OUT_MIN:   out_min_ff   <= csr_write_data;
            CSR_OUT_MAX:   out_max_ff   <= csr_write_data;
            CSR_THRESHOLD: threshold_ff <= csr_write_data[THRESH_WIDTH-1:0];
            CSR_AUTO_MODE: auto_mode_ff <= csr_write_data[0];
            default: begin
               // unused index, write dropped
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* hw/rtl/pidib_checker.sv */
// port level checks of the pid controller and their bind
`include "pid_controller_integral_bleed_top_assert.svh"

module pidib_checker
   import pidib_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_payload
);

   // a stalled result beat keeps its payload
   `PIDIB_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))

   // input back pressure only comes from a stalled result beat
   `PIDIB_ASSERT(a_stall_cause, clock, reset, req_stall |-> rsp_valid && rsp_stall)

   // reset empties both stages
   `PIDIB_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid && !req_stall)

endmodule

bind pid_controller_integral_bleed_top pidib_checker u_pidib_checker (.*);

/* bench/testbench.sv */
`timescale 1ns / 1ps
// self-checking bench for the pid controller with integral bleed
module testbench;
   import pidib_pkg::*;

   localparam int FRAC = 16;
   localparam int GAP_PERCENT = 27;
   localparam longint SAT_HI = 64'sd2147483647;
   localparam longint SAT_LO = -64'sd2147483648;
   localparam data_type DATA_MAX32 = 32'sh7fffffff;
   localparam data_type DATA_MIN32 = 32'sh80000000;
   localparam data_type UNITY = 32'sd65536;
   // index past the register list, the block should ignore it
   localparam csr_index_type CSR_UNUSED = 3'd7;

   // every input starts at a known value, reset held from time zero
   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_write_en = 1'b0;
   csr_index_type   csr_index = CSR_KP_GAIN;
   data_type        csr_write_data = '0;

   // controller shadow: registers and feedback state
   longint kp_q, ki_q, kd_q, lim_lo, lim_hi, thresh_q;
   bit     auto_q;
   longint integ_q, last_meas_q, held_q;

   // drive beats still owed by the block, oldest first
   rsp_payload_type pending_drive[$];
   int mismatch_count = 0;
   // random gaps on both channels
   bit gaps_on = 1'b1;

   always #2 clock = ~clock;

   pid_controller_integral_bleed_top #(
      .FRAC_BITS(FRAC)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_write_data(csr_write_data)
   );

   // ---------------------------------------------------------------- shadow model

   task automatic reset_shadow();
      kp_q        = 0;
      ki_q        = 0;
      kd_q        = 0;
      lim_lo      = longint'(OUT_MIN_RESET);
      lim_hi      = longint'(OUT_MAX_RESET);
      thresh_q    = 0;
      auto_q      = 1'b1;
      integ_q     = 0;
      last_meas_q = 0;
      held_q      = 0;
   endtask

   function automatic longint sat_data(longint v);
      if (v < SAT_LO) return SAT_LO;
      if (v > SAT_HI) return SAT_HI;
      return v;
   endfunction

   // lower bound first, then upper: inverted limits end at the upper one
   function automatic longint clamp_limits(longint v);
      longint r;
      r = v;
      if (r < lim_lo) r = lim_lo;
      if (r > lim_hi) r = lim_hi;
      return r;
   endfunction

   // exact product, floored back to q16.16; 32x32 always fits in 64 bits
   function automatic longint scale_product(longint gain, longint operand);
      return (gain * operand) >>> FRAC;
   endfunction

   // one controller sample; updates the shadow state
   function automatic rsp_payload_type compute_drive(req_payload_type s);
      longint err, abs_err, rate, sum, meas;
      rsp_payload_type r;
      r.updated = 1'b0;
      meas = longint'($signed(s.measurement));
      if (s.clear_memory) begin
         // clear wins over manual mode too
         integ_q     = 0;
         last_meas_q = 0;
      end else if (auto_q) begin
         err = sat_data(longint'($signed(s.setpoint)) - meas);
         abs_err = (err < 0) ? -err : err;
         if (abs_err >= thresh_q)
            integ_q = integ_q + scale_product(ki_q, err);
         else
            integ_q = integ_q - (integ_q >>> 2);   // bleed to three quarters, flooring
         integ_q = clamp_limits(integ_q);
         rate = s.use_external_rate ? longint'($signed(s.external_rate))
                                    : sat_data(meas - last_meas_q);
         sum = scale_product(kp_q, err) + integ_q - scale_product(kd_q, rate);
         held_q      = clamp_limits(sum);
         last_meas_q = meas;
         r.updated   = 1'b1;
      end
      r.drive = data_type'(held_q);
      return r;
   endfunction

   // ---------------------------------------------------------------- drivers

   // register write at a falling edge, shadow follows at once
   task automatic write_csr(csr_index_type idx, data_type value);
      csr_write_en   = 1'b1;
      csr_index      = idx;
      csr_write_data = value;
      case (idx)
         CSR_KP_GAIN:   kp_q     = longint'($signed(value));
         CSR_KI_GAIN:   ki_q     = longint'($signed(value));
         CSR_KD_GAIN:   kd_q     = longint'($signed(value));
         CSR_OUT_MIN:   lim_lo   = longint'($signed(value));
         CSR_OUT_MAX:   lim_hi   = longint'($signed(value));
         CSR_THRESHOLD: thresh_q = longint'(value[THRESH_WIDTH-1:0]);
         CSR_AUTO_MODE: auto_q   = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   task automatic configure(data_type kp, data_type ki, data_type kd, data_type lo,
                            data_type hi, data_type thr, logic auto_on);
      write_csr(CSR_KP_GAIN, kp);
      write_csr(CSR_KI_GAIN, ki);
      write_csr(CSR_KD_GAIN, kd);
      write_csr(CSR_OUT_MIN, lo);
      write_csr(CSR_OUT_MAX, hi);
      write_csr(CSR_THRESHOLD, thr);
      write_csr(CSR_AUTO_MODE, data_type'(auto_on));
   endtask

   // offer one req beat; entered and left at a falling edge, valid left high
   // so back-to-back beats never drop valid between them
   task automatic send_sample(req_payload_type s);
      while (gaps_on && $urandom_range(99) < GAP_PERCENT) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_payload = s;
      do @(posedge clock); while (req_stall);
      pending_drive.push_back(compute_drive(s));
      @(negedge clock);
   endtask

   // drop valid and let every owed beat come back before touching registers
   task automatic wait_idle();
      req_valid = 1'b0;
      while (pending_drive.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic req_payload_type make_sample(data_type sp, data_type meas,
                                                   data_type ext, logic use_ext, logic clr);
      req_payload_type s;
      s.setpoint          = sp;
      s.measurement       = meas;
      s.external_rate     = ext;
      s.use_external_rate = use_ext;
      s.clear_memory      = clr;
      return s;
   endfunction

   // rsp stall changes on the falling edge only
   always @(negedge clock)
      rsp_stall <= gaps_on && ($urandom_range(99) < GAP_PERCENT);

   // compare every accepted rsp beat with the oldest owed one
   always @(posedge clock) begin : check_result_beat
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_drive.size() == 0) begin
            $error("drive beat with nothing owed: actual %0d", $signed(rsp_payload.drive));
            mismatch_count++;
         end else begin
            want = pending_drive.pop_front();
            if (rsp_payload.drive !== want.drive) begin
               $error("drive mismatch: expected %0d, actual %0d",
                      $signed(want.drive), $signed(rsp_payload.drive));
               mismatch_count++;
            end
            if (rsp_payload.updated !== want.updated) begin
               $error("updated mismatch: expected %0b, actual %0b",
                      want.updated, rsp_payload.updated);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- tests

   // register defaults: zero gains give zero drive, clear holds it
   task automatic test_reset_values();
      send_sample(make_sample(DATA_MAX32, DATA_MIN32, DATA_MAX32, 1'b1, 1'b0));
      send_sample(make_sample(DATA_MIN32, DATA_MAX32, DATA_MIN32, 1'b0, 1'b0));
      send_sample(make_sample('0, '0, '0, 1'b0, 1'b1));
      send_sample(make_sample(UNITY, 2 * UNITY, '0, 1'b0, 1'b0));
   endtask

   // accumulate at the threshold, bleed just under it, both signs
   task automatic test_integral_paths();
      wait_idle();
      configure(UNITY, UNITY / 2, UNITY / 4, OUT_MIN_RESET, OUT_MAX_RESET, UNITY, 1'b1);
      send_sample(make_sample(UNITY, '0, '0, 1'b0, 1'b0));       // error equals threshold
      send_sample(make_sample(UNITY - 1, '0, '0, 1'b0, 1'b0));   // one lsb under, bleed
      send_sample(make_sample('0, 3 * UNITY + 5, '0, 1'b0, 1'b0)); // odd negative integral
      send_sample(make_sample(32'sd100, '0, '0, 1'b0, 1'b0));    // negative bleed floors
      send_sample(make_sample('0, '0, 8 * UNITY, 1'b1, 1'b0));   // external rate path
      send_sample(make_sample(UNITY, UNITY, '0, 1'b0, 1'b1));    // clear in auto mode
   endtask

   // saturated error and rate, extreme gains, sums past 32 bits
   task automatic test_saturation();
      wait_idle();
      configure(DATA_MIN32, DATA_MAX32, DATA_MIN32, DATA_MIN32, DATA_MAX32, '0, 1'b1);
      send_sample(make_sample(DATA_MAX32, DATA_MIN32, '0, 1'b0, 1'b0));
      send_sample(make_sample(DATA_MIN32, DATA_MAX32, '0, 1'b0, 1'b0));
      send_sample(make_sample('0, '0, DATA_MAX32, 1'b1, 1'b0));
      send_sample(make_sample('0, '0, DATA_MIN32, 1'b1, 1'b0));
      send_sample(make_sample('0, DATA_MIN32, '0, 1'b0, 1'b0));
      // largest threshold: only a saturated error still accumulates
      wait_idle();
      configure(UNITY, UNITY, UNITY, OUT_MIN_RESET, OUT_MAX_RESET, DATA_MAX32, 1'b1);
      send_sample(make_sample(DATA_MIN32, DATA_MAX32, '0, 1'b0, 1'b0));
      send_sample(make_sample('0, UNITY, '0, 1'b0, 1'b0));
      send_sample(make_sample(300 * UNITY, '0, '0, 1'b1, 1'b0)); // drive hits upper limit
   endtask

   // manual mode holds drive; clear still wipes the integral
   task automatic test_manual_and_clear();
      wait_idle();
      write_csr(CSR_UNUSED, DATA_MAX32);
      write_csr(CSR_AUTO_MODE, '0);
      send_sample(make_sample(50 * UNITY, '0, '0, 1'b0, 1'b0));
      send_sample(make_sample(50 * UNITY, UNITY, '0, 1'b0, 1'b1));
      wait_idle();
      write_csr(CSR_AUTO_MODE, data_type'(1));
      send_sample(make_sample(2 * UNITY, UNITY, '0, 1'b0, 1'b0));
   endtask

   // out_min above out_max: integral and drive pinned at out_max
   task automatic test_inverted_limits();
      wait_idle();
      write_csr(CSR_OUT_MIN, 10 * UNITY);
      write_csr(CSR_OUT_MAX, -10 * UNITY);
      send_sample(make_sample(DATA_MAX32, '0, '0, 1'b0, 1'b0));
      send_sample(make_sample(DATA_MIN32, '0, '0, 1'b1, 1'b0));
   endtask

   function automatic data_type pick_gain();
      data_type g;
      case ($urandom_range(4))
         0, 1:    g = data_type'($urandom_range(0, 4 * 65536));   // up to 4.0
         2:       g = data_type'($urandom_range(0, 65536));
         3:       g = data_type'($urandom);
         default: g = $urandom_range(1) ? DATA_MAX32 : DATA_MIN32;
      endcase
      if ($urandom_range(1)) g = -g;
      return g;
   endfunction

   function automatic data_type pick_threshold();
      case ($urandom_range(3))
         0:       return '0;
         1:       return data_type'($urandom);   // upper bit is dropped by the block
         default: return data_type'($urandom_range(0, 4 * 65536));
      endcase
   endfunction

   // phases of closed-loop style traffic: measurement walks, setpoint steps,
   // with a share of raw noise beats mixed in
   task automatic test_random_traffic();
      req_payload_type s;
      data_type lo, hi, swap, level, target, step;
      for (int phase = 0; phase < 11; phase++) begin
         wait_idle();
         lo = data_type'($urandom) >>> $urandom_range(0, 12);
         hi = data_type'($urandom) >>> $urandom_range(0, 12);
         if (phase == 0) begin
            lo = DATA_MIN32;
            hi = DATA_MAX32;
         end else if (phase == 1 ? (lo < hi) : (lo > hi && $urandom_range(99) < 80)) begin
            swap = lo;
            lo   = hi;
            hi   = swap;
         end
         configure(pick_gain(), pick_gain(), pick_gain(), lo, hi, pick_threshold(),
                   (phase < 2) || ($urandom_range(9) != 0));
         // two phases back to back without any gap on either side
         gaps_on = !(phase == 4 || phase == 5);
         level  = data_type'($urandom) >>> $urandom_range(8, 20);
         target = level;
         for (int n = 0; n < 50; n++) begin
            if ($urandom_range(99) < 20) begin
               s.setpoint      = $urandom;
               s.measurement   = $urandom;
               s.external_rate = $urandom;
            end else begin
               if ($urandom_range(99) < 6)
                  target = data_type'($urandom) >>> $urandom_range(8, 20);
               step  = data_type'($urandom) >>> $urandom_range(12, 22);
               level = data_type'(sat_data(longint'(level) + longint'(step)));
               s.setpoint      = target;
               s.measurement   = level;
               s.external_rate = data_type'($urandom) >>> $urandom_range(8, 24);
            end
            s.use_external_rate = $urandom_range(99) < 30;
            s.clear_memory      = $urandom_range(99) < 4;
            send_sample(s);
         end
      end
      gaps_on = 1'b1;
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      reset_shadow();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_values();
      test_integral_paths();
      test_saturation();
      test_manual_and_clear();
      test_inverted_limits();
      test_random_traffic();

      // everything back, then wait for any stray beat
      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* pid_controller_integral_bleed_top.f */
+incdir+hw/rtl
hw/rtl/pidib_pkg.sv
hw/rtl/pidib_term.sv
hw/rtl/pidib_clamp.sv
hw/rtl/pid_controller_integral_bleed_top.sv
hw/rtl/pidib_checker.sv
bench/testbench.sv
